// ===== sv/mpq_pkg.sv =====
// Shared types and constants of the multilevel priority task queue.
`default_nettype none
package mpq_pkg;
	localparam int NUM_CAP_REGS = 5;
	localparam logic [11:0] CAP_RESET [NUM_CAP_REGS] = '{12'd2048, 12'd1024, 12'd512, 12'd256, 12'd64};

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_DEQ    = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  priority_req;
		logic [31:0] payload;
		logic [31:0] target_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] task_id;
		logic [31:0] payload_out;
		logic [2:0]  level_out;
	} rsp_t;
endpackage
`default_nettype wire

// ===== sv/mpq_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration writes.
`default_nettype none
interface mpq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [2:0]  priority_req;
	logic [31:0] payload;
	logic [31:0] target_id;
	modport source (output valid, cmd, priority_req, payload, target_id, input ready);
	modport sink (input valid, cmd, priority_req, payload, target_id, output ready);
endinterface

interface mpq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] task_id;
	logic [31:0] payload_out;
	logic [2:0]  level_out;
	modport source (output valid, status, task_id, payload_out, level_out, input ready);
	modport sink (input valid, status, task_id, payload_out, level_out, output ready);
endinterface

interface mpq_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [11:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/mpq_front.sv =====
// Front end: request intake into a two-entry queue toward the engine.
`default_nettype none
module mpq_front
	import mpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mpq_req_if.sink   req,
	output req_t      q_data,
	output logic      q_valid,
	input  wire logic q_pop
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{req.cmd, req.priority_req, req.payload, req.target_id};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/mpq_engine.sv =====
// Back end: level memory, pointers, and the enqueue/dequeue/cancel sequencer.
`default_nettype none
module mpq_engine
	import mpq_pkg::*;
#(
	parameter int LEVEL_DEPTH = 2048,
	parameter int NUM_LEVELS = 5,
	parameter int ID_WIDTH = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  req_t      q_data,
	input  wire logic q_valid,
	output logic      q_pop,
	mpq_cfg_if.sink   cfg,
	mpq_rsp_if.source rsp
);
	localparam int AW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int LW = $clog2(NUM_LEVELS);
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int MW = LW + AW;
	localparam int EW = ID_WIDTH + PAYLOAD_WIDTH;
	localparam logic [CW-1:0] DEPTH_C = CW'(LEVEL_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_DEQ, S_CSCAN, S_CHECK, S_SHIFT, S_OUT} state_t;

	state_t             state_q;
	logic [EW-1:0]      mem [NUM_LEVELS * LEVEL_DEPTH];
	logic [EW-1:0]      rd_q;
	logic [AW-1:0]      head_q [NUM_LEVELS];
	logic [CW-1:0]      count_q [NUM_LEVELS];
	logic [11:0]        cap_q [NUM_CAP_REGS];
	logic [ID_WIDTH-1:0] next_id_q;
	req_t               cur_q;
	logic [LW-1:0]      lvl_q;
	logic [CW-1:0]      k_q;
	logic               sh_q;
	logic               ovalid_q;
	rsp_t               out_q;
	logic [CW-1:0]      cap_eff [NUM_LEVELS];
	logic [LW-1:0]      enq_lvl, deq_lvl;
	logic               any_nonempty;
	logic [MW-1:0]      rd_addr;
	logic               rd_en;

	function automatic logic [MW-1:0] addr_of(logic [LW-1:0] l, logic [AW-1:0] h,
		logic [CW-1:0] k);
		logic [CW:0] s;
		s = {{(CW-AW+1){1'b0}}, h} + {1'b0, k};
		if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
		return MW'(l * LEVEL_DEPTH) + MW'(s);
	endfunction

	assign cfg.ready = 1'b1;

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (i < NUM_CAP_REGS) begin
				cap_eff[i] = ({1'b0, cap_q[i]} > 13'(LEVEL_DEPTH)) ? DEPTH_C : CW'(cap_q[i]);
			end else begin
				cap_eff[i] = DEPTH_C;
			end
		end
		enq_lvl = (q_data.priority_req > 3'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1)
			: LW'(q_data.priority_req);
		deq_lvl = '0;
		any_nonempty = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (count_q[i] != '0) begin
				deq_lvl = LW'(i);
				any_nonempty = 1'b1;
			end
		end
	end

	// Read port: dequeue head, or the scan position; during a shift, the next entry.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = addr_of(lvl_q, head_q[lvl_q], k_q);
		if (state_q == S_IDLE && q_valid && !ovalid_q && q_data.cmd == CMD_DEQ) begin
			rd_en = 1'b1;
			rd_addr = addr_of(deq_lvl, head_q[deq_lvl], '0);
		end else if (state_q == S_CSCAN) begin
			rd_en = 1'b1;
		end else if (state_q == S_SHIFT) begin
			rd_en = 1'b1;
			rd_addr = addr_of(lvl_q, head_q[lvl_q], k_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
		if (state_q == S_IDLE && q_valid && !ovalid_q && q_data.cmd == CMD_ENQ &&
			count_q[enq_lvl] < cap_eff[enq_lvl]) begin
			mem[addr_of(enq_lvl, head_q[enq_lvl], count_q[enq_lvl])] <=
				{next_id_q + 1'b1, PAYLOAD_WIDTH'(q_data.payload)};
		end
		// Shift writes the entry read last cycle into the slot before it. On the
		// first shift cycle rd_q still holds the matched entry, so nothing is written.
		if (state_q == S_SHIFT && sh_q) begin
			mem[addr_of(lvl_q, head_q[lvl_q], k_q - 1'b1)] <= rd_q;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && !ovalid_q;
	assign rsp.valid = ovalid_q;
	assign rsp.status = out_q.status;
	assign rsp.task_id = out_q.task_id;
	assign rsp.payload_out = out_q.payload_out;
	assign rsp.level_out = out_q.level_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
			next_id_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
			for (int i = 0; i < NUM_CAP_REGS; i++) cap_q[i] <= CAP_RESET[i];
			lvl_q <= '0; k_q <= '0; sh_q <= 1'b0; cur_q <= '0; out_q <= '0;
		end else begin
			if (cfg.valid && 32'(cfg.index) < NUM_CAP_REGS) cap_q[cfg.index] <= cfg.data;
			if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cur_q <= q_data;
						case (q_data.cmd)
							CMD_ENQ: begin
								ovalid_q <= 1'b1;
								if (count_q[enq_lvl] < cap_eff[enq_lvl]) begin
									next_id_q <= next_id_q + 1'b1;
									count_q[enq_lvl] <= count_q[enq_lvl] + 1'b1;
									out_q <= '{ST_OK, 32'(next_id_q + 1'b1), 32'd0,
										3'(enq_lvl)};
								end else begin
									out_q <= '{ST_FULL, 32'd0, 32'd0, 3'(enq_lvl)};
								end
							end
							CMD_DEQ: begin
								if (any_nonempty) begin
									lvl_q <= deq_lvl;
									state_q <= S_DEQ;
								end else begin
									ovalid_q <= 1'b1;
									out_q <= '{ST_EMPTY, 32'd0, 32'd0, 3'd0};
								end
							end
							CMD_CANCEL: begin
								lvl_q <= '0;
								k_q <= '0;
								state_q <= S_CSCAN;
							end
							default: begin
								ovalid_q <= 1'b1;
								out_q <= '{ST_OK, 32'd0, 32'd0, 3'd0};
							end
						endcase
					end
				end
				S_DEQ: begin
					ovalid_q <= 1'b1;
					out_q <= '{ST_OK, 32'(rd_q[EW-1:PAYLOAD_WIDTH]),
						32'(rd_q[PAYLOAD_WIDTH-1:0]), 3'(lvl_q)};
					head_q[lvl_q] <= (32'(head_q[lvl_q]) == LEVEL_DEPTH - 1) ? '0
						: head_q[lvl_q] + 1'b1;
					count_q[lvl_q] <= count_q[lvl_q] - 1'b1;
					state_q <= S_IDLE;
				end
				S_CSCAN: begin
					// Step past exhausted levels before reading.
					if (k_q >= count_q[lvl_q]) begin
						if (32'(lvl_q) == NUM_LEVELS - 1) begin
							out_q <= '{ST_NOTFOUND, 32'd0, 32'd0, 3'd0};
							state_q <= S_OUT;
						end else begin
							lvl_q <= lvl_q + 1'b1;
							k_q <= '0;
						end
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (rd_q[EW-1:PAYLOAD_WIDTH] == ID_WIDTH'(cur_q.target_id)) begin
						out_q <= '{ST_OK, 32'(rd_q[EW-1:PAYLOAD_WIDTH]),
							32'(rd_q[PAYLOAD_WIDTH-1:0]), 3'(lvl_q)};
						sh_q <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_CSCAN;
					end
				end
				S_SHIFT: begin
					// Read k+1 now; the write of slot k happens on the next pass.
					sh_q <= 1'b1;
					if (k_q + 1'b1 >= count_q[lvl_q]) begin
						count_q[lvl_q] <= count_q[lvl_q] - 1'b1;
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_OUT: begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/multilevel_priority_task_queue_unit.sv =====
// Top level of the multilevel priority task queue.
// Requests enter on req (cmd, priority_req, payload, target_id) through a
// two-entry queue; each yields exactly one result on rsp. A request reaches
// the engine in the cycle after it is accepted at the earliest.
// Enqueue, empty dequeue and unused commands present their result in the
// cycle after the engine takes them; a dequeue first passes S_DEQ (one memory
// read). The engine takes its next request the cycle after the result is
// accepted, so it works on one request at a time.
// Cancel walks the level memory through its single read port: each entry up
// to the match is read in S_CSCAN and compared in S_CHECK, each exhausted
// level is stepped past in S_CSCAN, then the entries from the match to the
// end of that level shift down in S_SHIFT, and S_OUT presents the result.
// cfg writes capacity registers at index 0..4; it is always ready and is
// meant to be used while the block is idle.
// Reset clears all levels and the id counter at once; the level memory
// needs no clearing. The result register holds while rsp.ready is low and
// the engine takes no new request until it drains; the front queue keeps
// accepting until it holds two requests.
`default_nettype none
module multilevel_priority_task_queue_unit
	import mpq_pkg::*;
#(
	parameter int LEVEL_DEPTH = 2048,
	parameter int NUM_LEVELS = 5,
	parameter int ID_WIDTH = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp,
	mpq_cfg_if.sink   cfg
);
	req_t q_data;
	logic q_valid, q_pop;

	mpq_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	mpq_engine #(
		.LEVEL_DEPTH(LEVEL_DEPTH), .NUM_LEVELS(NUM_LEVELS),
		.ID_WIDTH(ID_WIDTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .cfg(cfg), .rsp(rsp)
	);
endmodule
`default_nettype wire

// ===== tb/multilevel_priority_task_queue_unit_test.sv =====
// Self-checking testbench of the multilevel priority task queue unit.
`timescale 1ns / 1ps
module multilevel_priority_task_queue_unit_test;
	import mpq_pkg::*;

	localparam int DEPTH = 2048;
	localparam int LEVELS = 5;
	localparam int FILL_COUNT = 100;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		REG_CAP_BACKGROUND = 3'd0,
		REG_CAP_LOW        = 3'd1,
		REG_CAP_NORMAL     = 3'd2,
		REG_CAP_HIGH       = 3'd3,
		REG_CAP_REALTIME   = 3'd4
	} cap_reg_e;

	typedef struct {
		logic [31:0] id;
		logic [31:0] pay;
	} queued_task_t;

	logic clk;
	logic arst_n;

	mpq_req_if req_ch();
	mpq_rsp_if rsp_ch();
	mpq_cfg_if cfg_ch();

	multilevel_priority_task_queue_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	// Mirror of the queue contents, capacities and id counter.
	queued_task_t level_tasks [LEVELS][$];
	logic [11:0] level_cap [LEVELS];
	logic [31:0] last_task_id;

	rsp_t due_results [$];
	int failures = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	int n_cmd [4] = '{0, 0, 0, 0};
	int n_results = 0;
	int n_full = 0;
	int n_cancel_hit = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multilevel_priority_task_queue_unit verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (due_results.size() == 0) begin
				$error("result with no request outstanding: status %0d id %h",
					rsp_ch.status, rsp_ch.task_id);
				failures++;
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					failures++;
				end
				if (rsp_ch.task_id !== want.task_id) begin
					$error("task_id: expected %h, got %h", want.task_id, rsp_ch.task_id);
					failures++;
				end
				if (rsp_ch.payload_out !== want.payload_out) begin
					$error("payload_out: expected %h, got %h", want.payload_out,
						rsp_ch.payload_out);
					failures++;
				end
				if (rsp_ch.level_out !== want.level_out) begin
					$error("level_out: expected %0d, got %0d", want.level_out,
						rsp_ch.level_out);
					failures++;
				end
			end
		end
	end

	function automatic int usable_cap(int lvl);
		return (level_cap[lvl] > DEPTH) ? DEPTH : int'(level_cap[lvl]);
	endfunction

	function automatic rsp_t predict_queue_op(req_t r);
		rsp_t res;
		int lvl;
		queued_task_t t;
		res = '{status: ST_OK, task_id: '0, payload_out: '0, level_out: '0};
		case (r.cmd)
			CMD_ENQ: begin
				lvl = (r.priority_req > LEVELS - 1) ? LEVELS - 1 : int'(r.priority_req);
				res.level_out = lvl[2:0];
				if (level_tasks[lvl].size() >= usable_cap(lvl)) begin
					res.status = ST_FULL;
					n_full++;
				end else begin
					last_task_id = last_task_id + 32'd1;
					t.id = last_task_id;
					t.pay = r.payload;
					level_tasks[lvl].push_back(t);
					res.task_id = last_task_id;
				end
			end
			CMD_DEQ: begin
				res.status = ST_EMPTY;
				for (int l = LEVELS - 1; l >= 0; l--) begin
					if (res.status == ST_EMPTY && level_tasks[l].size() != 0) begin
						t = level_tasks[l].pop_front();
						res = '{status: ST_OK, task_id: t.id, payload_out: t.pay,
							level_out: l[2:0]};
					end
				end
			end
			CMD_CANCEL: begin
				res.status = ST_NOTFOUND;
				// Lowest level first, oldest first; only the first match goes.
				for (int l = 0; l < LEVELS; l++) begin
					for (int k = 0; k < level_tasks[l].size(); k++) begin
						if (res.status == ST_NOTFOUND && level_tasks[l][k].id == r.target_id) begin
							t = level_tasks[l][k];
							level_tasks[l].delete(k);
							res = '{status: ST_OK, task_id: t.id, payload_out: t.pay,
								level_out: l[2:0]};
							n_cancel_hit++;
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_request(req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.priority_req <= r.priority_req;
		req_ch.payload <= r.payload;
		req_ch.target_id <= r.target_id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		n_cmd[r.cmd]++;
		due_results.push_back(predict_queue_op(r));
	endtask

	task automatic send_op(logic [1:0] c, logic [2:0] p, logic [31:0] pay, logic [31:0] id);
		req_t r;
		r.cmd = c;
		r.priority_req = p;
		r.payload = pay;
		r.target_id = id;
		send_request(r);
	endtask

	// Drops valid and waits until every outstanding request has its result.
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(cap_reg_e r, logic [11:0] v);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		level_cap[r] = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic req_t random_request();
		req_t r;
		int pick;
		int l;
		r.cmd = CMD_ENQ;
		r.priority_req = $urandom_range(7);
		r.payload = $urandom;
		r.target_id = $urandom;
		pick = $urandom_range(99);
		if (pick < 42) begin
			r.cmd = CMD_ENQ;
		end else if (pick < 67) begin
			r.cmd = CMD_DEQ;
		end else if (pick < 90) begin
			r.cmd = CMD_CANCEL;
			l = $urandom_range(LEVELS - 1);
			if (level_tasks[l].size() != 0)
				r.target_id = level_tasks[l][$urandom_range(level_tasks[l].size() - 1)].id;
			else if (last_task_id != 0)
				r.target_id = last_task_id - $urandom_range(3);
		end else if (pick < 97) begin
			r.cmd = CMD_CANCEL;
		end else begin
			r.cmd = CMD_UNUSED;
		end
		return r;
	endfunction

	task automatic test_directed();
		set_capacity(REG_CAP_LOW, 12'd2);
		set_capacity(REG_CAP_REALTIME, 12'd1);
		send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
		send_op(CMD_CANCEL, 3'd0, 32'h0, 32'hffff_ffff);
		send_op(CMD_UNUSED, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
		send_op(CMD_ENQ, 3'd7, 32'hffff_ffff, 32'h0);
		send_op(CMD_ENQ, 3'd5, 32'h1234_5678, 32'h0);
		send_op(CMD_ENQ, 3'd1, 32'h0, 32'h0);
		send_op(CMD_ENQ, 3'd1, 32'h1, 32'h0);
		send_op(CMD_ENQ, 3'd1, 32'h2, 32'h0);
		send_op(CMD_ENQ, 3'd0, 32'h8000_0000, 32'h0);
		send_op(CMD_ENQ, 3'd3, 32'h5555_aaaa, 32'h0);
		send_op(CMD_ENQ, 3'd2, 32'haaaa_5555, 32'h0);
		send_op(CMD_CANCEL, 3'd0, 32'h0, last_task_id - 32'd4);
		send_op(CMD_CANCEL, 3'd0, 32'h0, 32'h0);
		repeat (6) send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
	endtask

	// A level filled past its new capacity keeps its tasks; a zero capacity refuses all.
	task automatic test_capacity_lowered();
		set_capacity(REG_CAP_NORMAL, 12'd4);
		repeat (3) send_op(CMD_ENQ, 3'd2, $urandom, 32'h0);
		set_capacity(REG_CAP_NORMAL, 12'd1);
		send_op(CMD_ENQ, 3'd2, $urandom, 32'h0);
		send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
		send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
		send_op(CMD_ENQ, 3'd2, $urandom, 32'h0);
		send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
		send_op(CMD_ENQ, 3'd2, $urandom, 32'h0);
		set_capacity(REG_CAP_HIGH, 12'd0);
		send_op(CMD_ENQ, 3'd3, $urandom, 32'h0);
		send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
	endtask

	// A capacity above the level depth sets no early limit; a long level is
	// then cancelled from the middle and the end, and drained.
	task automatic test_full_depth();
		set_capacity(REG_CAP_BACKGROUND, 12'hfff);
		repeat (FILL_COUNT) send_op(CMD_ENQ, 3'd0, $urandom, 32'h0);
		send_op(CMD_CANCEL, 3'd0, 32'h0, level_tasks[0][FILL_COUNT / 2].id);
		send_op(CMD_CANCEL, 3'd0, 32'h0, last_task_id);
		send_op(CMD_ENQ, 3'd0, $urandom, 32'h0);
		repeat (FILL_COUNT + 1) send_op(CMD_DEQ, 3'd0, 32'h0, 32'h0);
	endtask

	// The receiver stalls long enough for the input side to back up.
	task automatic test_backpressure();
		wait_idle();
		recv_hold = 300;
		repeat (30) send_request(random_request());
		wait_idle();
	endtask

	task automatic test_random_phase(int n);
		for (int i = 0; i < LEVELS; i++) begin
			case ($urandom_range(5))
				0: set_capacity(cap_reg_e'(i), 12'd0);
				1: set_capacity(cap_reg_e'(i), 12'hfff);
				2: set_capacity(cap_reg_e'(i), 12'd2048);
				default: set_capacity(cap_reg_e'(i), 12'($urandom_range(1, 12)));
			endcase
		end
		repeat (n) send_request(random_request());
	endtask

	initial begin
		for (int i = 0; i < LEVELS; i++) level_cap[i] = CAP_RESET[i];
		last_task_id = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ENQ;
		req_ch.priority_req = '0;
		req_ch.payload = '0;
		req_ch.target_id = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CAP_BACKGROUND;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 46;
		test_directed();
		test_capacity_lowered();
		test_full_depth();
		test_backpressure();
		test_random_phase(200);
		test_random_phase(200);
		send_idle_pct = 46;
		recv_idle_pct = 25;
		test_random_phase(200);
		test_random_phase(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_phase(200);
		test_random_phase(200);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d enqueues (%0d refused), %0d dequeues, %0d cancels (%0d hits),",
			n_cmd[CMD_ENQ], n_full, n_cmd[CMD_DEQ], n_cmd[CMD_CANCEL], n_cancel_hit);
		$display("%0d unused commands and %0d checked results in %0d cycles.",
			n_cmd[CMD_UNUSED], n_results, cycles);
		if (failures == 0)
			$display("multilevel_priority_task_queue_unit verification clean");
		else
			$display("multilevel_priority_task_queue_unit verification failed");
		$finish;
	end
endmodule
